// File: src/acrl_pkg.sv
package acrl_pkg;

  localparam int MAX_CHUNK = 512;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W = 17;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  // Sample count saturates at MAX_CHUNK, so it must be able to hold that value.
  localparam int CNT_W = $clog2(MAX_CHUNK + 1);
  // A square is at most 2**30, so 31 bits hold it without loss.
  localparam int SQ_W = 31;
  localparam int SUM_W = SQ_W + $clog2(MAX_CHUNK);

  localparam int ROOT_W = 16;
  localparam int SQRT_IN_W = 2 * ROOT_W;
  localparam int SQRT_REM_W = ROOT_W + 1;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam int PROD_W = 34;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 17'd65536;
  localparam logic [CFG_W-1:0] KEEP_RESET = 16'd45875;
  localparam logic [CFG_W-1:0] DECAY_RESET = 16'd52429;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOOTH_KEEP = 1'b0,
    CFG_TICK_DECAY  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       play;
    logic                       last;
    logic [SUM_W-1:0]           sum;
    logic [CNT_W-1:0]           count;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qport_t;

  typedef struct packed {
    logic [CFG_W-1:0] keep;
    logic [CFG_W-1:0] decay;
  } cfg_t;

endpackage

// File: src/acrl_if.sv
interface acrl_in_if;
  import acrl_pkg::*;

  logic                       valid;
  logic                       ready;
  op_t                        op;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source(output valid, op, sample, last, input ready);
  modport sink(input valid, op, sample, last, output ready);
endinterface

interface acrl_out_if;
  import acrl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       play_valid;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic [LEVEL_W-1:0]         level;
  logic                       level_updated;

  modport source(output valid, play_valid, left_out, right_out, level, level_updated,
                 input ready);
  modport sink(input valid, play_valid, left_out, right_out, level, level_updated,
               output ready);
endinterface

// File: src/audio_chunk_rms_level_tracker.sv
// Chunked RMS level meter. Each sample item returns one result: the sample copied
// to left and right (dropped past MAX_CHUNK samples of a chunk) and the current
// Q1.16 level. A sample that ends no chunk is answered straight from the queue;
// the last sample of a chunk passes through the serial divider (one quotient bit
// a cycle), the serial square root (one root bit a cycle) and the S_MUL_OLD and
// S_MUL_NEW products, and a tick through its decay product. A four-entry queue
// lets the front end keep accepting and summing samples while a chunk end is
// computed. Write configuration only while no item is in flight.
module audio_chunk_rms_level_tracker (
  input  logic                          clk,
  input  logic                          rst,
  acrl_in_if.sink                       samples,
  acrl_out_if.source                    results,
  input  logic                          cfg_we,
  input  logic [acrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acrl_pkg::CFG_W-1:0]    cfg_data
);
  import acrl_pkg::*;

  cfg_t   cfg;
  qport_t push;
  qport_t head;
  logic   q_full;
  logic   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keep <= KEEP_RESET;
      cfg.decay <= DECAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SMOOTH_KEEP: cfg.keep <= cfg_data;
        CFG_TICK_DECAY:  cfg.decay <= cfg_data;
      endcase
    end
  end

  acrl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .push    (push),
    .q_full  (q_full)
  );

  acrl_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  acrl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .cfg     (cfg),
    .results (results)
  );

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.level <= LEVEL_FULL)
    else $error("level above full scale");

  a_dropped_silent: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.play_valid |-> results.left_out == '0)
    else $error("dropped sample carries audio");

  a_queue_flow: assert property (@(posedge clk) disable iff (rst)
    push.valid && q_full |-> !samples.ready)
    else $error("front accepted an item while the queue was full");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("back end popped an empty queue");
`endif

endmodule

// File: src/acrl_front.sv
module acrl_front (
  input  logic             clk,
  input  logic             rst,
  acrl_in_if.sink          samples,
  output acrl_pkg::qport_t push,
  input  logic             q_full
);
  import acrl_pkg::*;

  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic             s1_valid;
  entry_t           s1;
  logic [SQ_W-1:0]  s1_sq;

  logic             accept;
  logic             advance;
  logic             play;
  logic [CNT_W-1:0] count_inc;
  logic signed [31:0] sq_full;
  logic [SUM_W-1:0] sum_total;

  assign advance = s1_valid && !q_full;
  assign samples.ready = !s1_valid || !q_full;
  assign accept = samples.valid && samples.ready;
  assign play = (samples.op == OP_SAMPLE) && (count < CNT_W'(MAX_CHUNK));
  assign count_inc = count + CNT_W'(play);
  assign sq_full = 32'(samples.sample) * 32'(samples.sample);
  assign sum_total = sum + SUM_W'(s1_sq);

  // The queued item carries the chunk total including its own square.
  always_comb begin
    push.valid = s1_valid;
    push.entry = s1;
    push.entry.sum = sum_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      count <= '0;
      sum <= '0;
    end else begin
      if (advance && s1.op == OP_SAMPLE) begin
        sum <= s1.last ? '0 : sum_total;
      end
      if (accept) begin
        s1_valid <= 1'b1;
        count <= (samples.op == OP_SAMPLE && samples.last) ? '0 : count_inc;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.op <= samples.op;
      s1.sample <= samples.sample;
      s1.play <= play;
      s1.last <= samples.last;
      s1.sum <= '0;
      s1.count <= count_inc;
      s1_sq <= play ? sq_full[SQ_W-1:0] : '0;
    end
  end

endmodule

// File: src/acrl_fifo.sv
module acrl_fifo (
  input  logic             clk,
  input  logic             rst,
  input  acrl_pkg::qport_t push,
  output logic             full,
  output acrl_pkg::qport_t head,
  input  logic             pop
);
  import acrl_pkg::*;

  entry_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign full = fill == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign head.valid = fill != '0;
  assign head.entry = slots[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop = pop && head.valid;

  // Depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (FIFO_AW + 1)'(do_push) - (FIFO_AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

endmodule

// File: src/acrl_back.sv
module acrl_back (
  input  logic             clk,
  input  logic             rst,
  input  acrl_pkg::qport_t head,
  output logic             pop,
  input  acrl_pkg::cfg_t   cfg,
  acrl_out_if.source       results
);
  import acrl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SQRT,
    S_MUL_OLD,
    S_MUL_NEW,
    S_FINISH
  } state_t;

  state_t                     state;
  logic [STEP_W-1:0]          step;
  logic [LEVEL_W-1:0]         level;
  logic                       cur_play;
  logic signed [SAMPLE_W-1:0] cur_sample;

  logic [SUM_W-1:0]           div_q;
  logic [CNT_W-1:0]           div_rem;
  logic [CNT_W-1:0]           divisor;
  logic [SQRT_IN_W-1:0]       sq_v;
  logic [SQRT_REM_W-1:0]      sq_rem;
  logic [ROOT_W-1:0]          sq_root;
  logic [PROD_W-1:0]          prod_a;
  logic [PROD_W-1:0]          prod_b;

  logic                       out_valid;
  logic                       out_play;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic [LEVEL_W-1:0]         out_level;
  logic                       out_updated;

  logic                       out_free;
  logic                       out_load;
  logic [CNT_W:0]             div_sh;
  logic                       div_ge;
  logic [CNT_W-1:0]           div_rem_next;
  logic [SUM_W-1:0]           div_q_next;
  logic [SQRT_IN_W-1:0]       mean_sq;
  logic [SQRT_REM_W+1:0]      sq_sh;
  logic [SQRT_REM_W+1:0]      sq_trial;
  logic                       sq_ge;
  logic [SQRT_REM_W-1:0]      sq_rem_next;
  logic [ROOT_W-1:0]          sq_root_next;
  logic [LEVEL_W-1:0]         root2;
  logic [LEVEL_W-1:0]         weight_new;
  logic [32:0]                mul_old;
  logic [33:0]                mul_new;
  logic [32:0]                mul_tick;
  logic [PROD_W:0]            total;
  logic [PROD_W-16:0]         scaled;
  logic [LEVEL_W-1:0]         new_level;

  assign out_free = !out_valid || results.ready;
  assign pop = (state == S_IDLE) && head.valid &&
               (head.entry.op == OP_TICK || head.entry.last || out_free);
  // A result is loaded either straight from the queue or when a level update finishes.
  assign out_load = (pop && head.entry.op == OP_SAMPLE && !head.entry.last) ||
                    (state == S_FINISH && out_free);

  // Restoring division of the chunk total by the sample count, one bit a cycle.
  assign div_sh = {div_rem, div_q[SUM_W-1]};
  assign div_ge = div_sh >= {1'b0, divisor};
  assign div_rem_next = div_ge ? CNT_W'(div_sh - {1'b0, divisor}) : div_sh[CNT_W-1:0];
  assign div_q_next = {div_q[SUM_W-2:0], div_ge};
  // An empty chunk cannot reach here, but a zero count is still read as silence.
  assign mean_sq = (divisor == '0) ? '0 : SQRT_IN_W'(div_q_next[SQ_W-1:0]);

  // Digit-by-digit square root, one result bit a cycle.
  assign sq_sh = {sq_rem, sq_v[SQRT_IN_W-1 -: 2]};
  assign sq_trial = (SQRT_REM_W + 2)'({sq_root, 2'b01});
  assign sq_ge = sq_sh >= sq_trial;
  assign sq_rem_next = sq_ge ? SQRT_REM_W'(sq_sh - sq_trial) : SQRT_REM_W'(sq_sh);
  assign sq_root_next = {sq_root[ROOT_W-2:0], sq_ge};

  assign root2 = ({sq_root, 1'b0} > LEVEL_FULL) ? LEVEL_FULL : {sq_root, 1'b0};
  assign weight_new = LEVEL_FULL - LEVEL_W'(cfg.keep);
  assign mul_old = cfg.keep * level;
  assign mul_new = weight_new * root2;
  assign mul_tick = level * cfg.decay;

  assign total = (PROD_W + 1)'(prod_a) + (PROD_W + 1)'(prod_b);
  assign scaled = total[PROD_W:16];
  assign new_level = (scaled > (PROD_W - 15)'(LEVEL_FULL)) ? LEVEL_FULL
                                                            : scaled[LEVEL_W-1:0];

  assign results.valid = out_valid;
  assign results.play_valid = out_play;
  assign results.left_out = out_sample;
  assign results.right_out = out_sample;
  assign results.level = out_level;
  assign results.level_updated = out_updated;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      level <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur_play <= head.entry.play;
            cur_sample <= head.entry.play ? head.entry.sample : '0;
            if (head.entry.op == OP_TICK) begin
              prod_a <= PROD_W'(mul_tick);
              prod_b <= '0;
              state <= S_FINISH;
            end else if (head.entry.last) begin
              div_q <= head.entry.sum;
              div_rem <= '0;
              divisor <= head.entry.count;
              step <= STEP_W'(DIV_STEPS - 1);
              state <= S_DIV;
            end else begin
              out_play <= head.entry.play;
              out_sample <= head.entry.play ? head.entry.sample : '0;
              out_level <= level;
              out_updated <= 1'b0;
            end
          end
        end
        S_DIV: begin
          div_q <= div_q_next;
          div_rem <= div_rem_next;
          if (step == '0) begin
            sq_v <= mean_sq;
            sq_rem <= '0;
            sq_root <= '0;
            step <= STEP_W'(SQRT_STEPS - 1);
            state <= S_SQRT;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_SQRT: begin
          sq_v <= {sq_v[SQRT_IN_W-3:0], 2'b00};
          sq_rem <= sq_rem_next;
          sq_root <= sq_root_next;
          step <= step - 1'b1;
          if (step == '0) begin
            state <= S_MUL_OLD;
          end
        end
        S_MUL_OLD: begin
          prod_a <= PROD_W'(mul_old);
          state <= S_MUL_NEW;
        end
        S_MUL_NEW: begin
          prod_b <= mul_new;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            level <= new_level;
            out_play <= cur_play;
            out_sample <= cur_sample;
            out_level <= new_level;
            out_updated <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
